// File: hw/rtl/kfce_pkg.sv
// shared types, constants and helper functions for the keyframe curve evaluator
// no dependencies; used by kfce_div, kfce_mul and keyframe_curve_evaluator_top
package kfce_pkg;

    localparam int MAX_KEYS_DEF = 64;

    localparam int FRAME_W = 16;
    localparam int LEVEL_W = 32;
    localparam int QUERY_W = 24;
    localparam int COUNT_W = 7;
    localparam int T_W     = 17;   // t in q0.16, up to 1.0
    localparam int T2_W    = 34;
    localparam int T3_W    = 51;
    localparam int SLP_W   = 48;   // slope times span
    localparam int ACC_W   = 64;
    localparam int MULB_W  = 18;   // signed multiplier digit stream
    localparam int MUL_STEPS = MULB_W;
    localparam int MUL_CW    = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = T_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // register map: byte address bit 2 picks the register
    localparam logic REG_KEY_COUNT = 1'b0;

    localparam logic [1:0] SEG_STEP   = 2'd0;
    localparam logic [1:0] SEG_LINEAR = 2'd1;
    localparam logic [1:0] SEG_CUBIC  = 2'd2;
    localparam logic [1:0] SEG_SKIP   = 2'd3;

    localparam logic [0:0] CMD_WRITE = 1'b0;
    localparam logic [0:0] CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0]        frame;
        logic signed [LEVEL_W-1:0] level;
        logic signed [LEVEL_W-1:0] leave;
        logic signed [LEVEL_W-1:0] arrive;
        logic [1:0]                mode;
    } t_key;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DIV   = 5'b00100,
        S_MLOAD = 5'b01000,
        S_MWAIT = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        OP_LIN, OP_T2, OP_T3, OP_LS, OP_AS, OP_H00, OP_H01, OP_H10, OP_H11
    } t_op;

    typedef struct packed {
        logic                     go;
        logic [2*QUERY_W-17:0]    num;   // offset q.8 shifted left by 8, 32 bits
        logic [FRAME_W-1:0]       den;
    } t_div_req;

    typedef struct packed {
        logic                     go;
        logic signed [ACC_W-1:0]  a;
        logic [MULB_W-1:0]        b;
        logic signed [ACC_W-1:0]  init;
    } t_mul_req;

    // hermite basis in q0.16, floored from exact q0.48 terms
    function automatic logic signed [MULB_W-1:0] hermite_basis(
        input logic [T_W-1:0]  t,
        input logic [T2_W-1:0] t2,
        input logic [T3_W-1:0] t3,
        input t_op             op
    );
        logic signed [ACC_W-1:0] x3;
        logic signed [ACC_W-1:0] x2s;
        logic signed [ACC_W-1:0] xt;
        logic signed [ACC_W-1:0] one;
        logic signed [ACC_W-1:0] s;
        x3  = $signed({13'd0, t3});
        x2s = $signed({14'd0, t2, 16'd0});
        xt  = $signed({15'd0, t, 32'd0});
        one = $signed(64'h0001_0000_0000_0000);
        case (op)
            OP_H00:  s = (x3 <<< 1) - (x2s <<< 1) - x2s + one;
            OP_H01:  s = (x2s <<< 1) + x2s - (x3 <<< 1);
            OP_H10:  s = x3 - (x2s <<< 1) + xt;
            OP_H11:  s = x3 - x2s;
            default: s = '0;
        endcase
        return s[32 +: MULB_W];
    endfunction

    // floor by 2^16 then clamp to the int32 range
    function automatic logic [LEVEL_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-17:0] x;
        x = acc[ACC_W-1:16];
        if ((&x[ACC_W-17:31]) || !(|x[ACC_W-17:31])) begin
            return x[LEVEL_W-1:0];
        end else if (x[ACC_W-17]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

// File: hw/rtl/kfce_div.sv
// bit-serial restoring divider: t = (offset << 8) / span, one quotient bit a cycle
// uses kfce_pkg for widths and the request struct
module kfce_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kfce_pkg::t_div_req             i_req,
    output logic                           o_done,
    output logic [kfce_pkg::T_W-1:0]       o_quot
);

    logic [kfce_pkg::FRAME_W-1:0] r_rem, n_rem;
    logic [kfce_pkg::T_W-1:0]     r_num, n_num;
    logic [kfce_pkg::FRAME_W-1:0] r_den;
    logic [kfce_pkg::DIV_CW-1:0]  r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [kfce_pkg::FRAME_W:0]   trial;
    logic                         ge;

    always_comb begin
        trial = {r_rem, r_num[kfce_pkg::T_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? 16'(trial - {1'b0, r_den}) : trial[kfce_pkg::FRAME_W-1:0];
        n_num = {r_num[kfce_pkg::T_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= kfce_pkg::DIV_CW'(kfce_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // high remainder bits start below the divisor since offset <= span << 8
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= {1'b0, i_req.num[31:kfce_pkg::T_W]};
            r_num <= i_req.num[kfce_pkg::T_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// File: hw/rtl/kfce_mul.sv
// shift-add multiply-accumulate, one multiplier bit a cycle, top bit weighs negative
// uses kfce_pkg for widths and the request struct
module kfce_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kfce_pkg::t_mul_req                    i_req,
    output logic                                  o_done,
    output logic signed [kfce_pkg::ACC_W-1:0]     o_acc
);

    logic signed [kfce_pkg::ACC_W-1:0] r_a;
    logic [kfce_pkg::MULB_W-1:0]       r_b;
    logic signed [kfce_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [kfce_pkg::MUL_CW-1:0]       r_cnt;
    logic                              r_busy;
    logic                              r_done;

    always_comb begin
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = (r_cnt == '0) ? r_acc - r_a : r_acc + r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= kfce_pkg::MUL_CW'(kfce_pkg::MUL_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= i_req.init;
        end else if (r_busy) begin
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// File: hw/rtl/keyframe_curve_evaluator_top.sv
// keyframe curve evaluator: key table, segment scan and serial interpolation sequencer
// depends on kfce_pkg, kfce_div and kfce_mul
//
// A write-key item (start with command 0) stores one key; busy stays low. An evaluate
// item scans the key table one entry a cycle through the table's registered read port,
// then runs a serial divide for t and one shared bit-serial multiplier for the products.
// An empty table returns its result without a scan; clamped, step and no-segment
// results need no divide or product, linear segments take one product and cubic
// segments eight. The result appears on o_curve_value for exactly one cycle with
// o_result_valid and cannot be held off.
// Entries are undefined until written; key_count above MAX_KEYS acts as MAX_KEYS.
module keyframe_curve_evaluator_top #(
    parameter int MAX_KEYS = kfce_pkg::MAX_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [0:0]  i_command,
    input  logic [5:0]  i_key_slot,
    input  logic [15:0] i_key_frame,
    input  logic signed [31:0] i_key_level,
    input  logic signed [31:0] i_leave_slope,
    input  logic signed [31:0] i_arrive_slope,
    input  logic [1:0]  i_key_mode,
    input  logic [23:0] i_query_frame,
    output logic signed [31:0] o_curve_value,
    output logic        o_result_valid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    kfce_pkg::t_state r_state;
    kfce_pkg::t_op    r_op;

    kfce_pkg::t_key r_mem [MAX_KEYS];
    kfce_pkg::t_key r_rdata;
    kfce_pkg::t_key r_prev;
    kfce_pkg::t_key wr_key;

    logic [kfce_pkg::COUNT_W-1:0] r_key_count;
    logic [CW-1:0]                n_keys;
    logic [CW-1:0]                r_n;
    logic [CW-1:0]                r_j;
    logic [AW-1:0]                r_ridx;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic                         r_first;
    logic [23:0]                  r_q;
    logic [15:0]                  r_last_frame;
    logic signed [31:0]           r_last_level;
    logic signed [31:0]           r_vl, r_vr, r_leave, r_arrive;
    logic [15:0]                  r_span;
    logic [1:0]                   r_mode;
    logic [kfce_pkg::T_W-1:0]     r_t;
    logic [kfce_pkg::T2_W-1:0]    r_t2;
    logic [kfce_pkg::T3_W-1:0]    r_t3;
    logic signed [kfce_pkg::SLP_W-1:0] r_ls, r_as;
    logic                         r_ovld;
    logic [31:0]                  r_oval;

    logic        acc_item;
    logic        acc_wr;
    logic        acc_eval;
    logic        cfg_wr;
    logic [23:0] lf, rf;
    logic [23:0] off;
    logic [15:0] span_raw, span;
    logic        in_seg;
    logic        div_done;
    logic        mul_done;
    logic [kfce_pkg::T_W-1:0]        div_quot;
    logic signed [kfce_pkg::ACC_W-1:0] mul_acc;
    kfce_pkg::t_div_req div_req;
    kfce_pkg::t_mul_req mul_req;

    assign busy     = (r_state != kfce_pkg::S_IDLE);
    assign acc_item = start && !busy;
    assign acc_wr   = acc_item && (i_command == kfce_pkg::CMD_WRITE);
    assign acc_eval = acc_item && (i_command == kfce_pkg::CMD_EVAL);
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == kfce_pkg::REG_KEY_COUNT);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == kfce_pkg::REG_KEY_COUNT) ? {25'd0, r_key_count} : '0;

    assign n_keys  = (32'(r_key_count) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(r_key_count);
    assign wr_addr = AW'(i_key_slot);
    assign rd_addr = (r_state == kfce_pkg::S_IDLE) ? AW'(n_keys - CW'(1)) : r_ridx;

    always_comb begin
        wr_key.frame  = i_key_frame;
        wr_key.level  = i_key_level;
        wr_key.leave  = i_leave_slope;
        wr_key.arrive = i_arrive_slope;
        wr_key.mode   = i_key_mode;
    end

    // key table: one write port from the item, one registered read port
    always_ff @(posedge i_clk) begin
        if (acc_wr && (32'(i_key_slot) < MAX_KEYS)) begin
            r_mem[wr_addr] <= wr_key;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // segment test against the previous entry
    always_comb begin
        lf       = {r_prev.frame, 8'd0};
        rf       = {r_rdata.frame, 8'd0};
        off      = r_q - lf;
        span_raw = r_rdata.frame - r_prev.frame;
        span     = (span_raw == '0) ? 16'd1 : span_raw;
        in_seg   = (r_q >= lf) && (r_q <= rf) && (r_prev.mode != kfce_pkg::SEG_SKIP);
    end

    always_comb begin
        div_req.go  = (r_state == kfce_pkg::S_SCAN) && !r_first && (r_j != '0) && in_seg
                      && (r_prev.mode != kfce_pkg::SEG_STEP);
        div_req.num = {off, 8'd0};
        div_req.den = span;
    end

    always_comb begin
        mul_req.go   = (r_state == kfce_pkg::S_MLOAD);
        mul_req.a    = '0;
        mul_req.b    = {1'b0, r_t};
        mul_req.init = mul_acc;
        case (r_op)
            kfce_pkg::OP_LIN: begin
                mul_req.a    = 64'(r_vr) - 64'(r_vl);
                mul_req.init = 64'(r_vl) <<< 16;
            end
            kfce_pkg::OP_T2: begin
                mul_req.a    = 64'(r_t);
                mul_req.init = '0;
            end
            kfce_pkg::OP_T3: begin
                mul_req.a    = 64'(r_t2);
                mul_req.init = '0;
            end
            kfce_pkg::OP_LS: begin
                mul_req.a    = 64'(r_leave);
                mul_req.b    = {2'b00, r_span};
                mul_req.init = '0;
            end
            kfce_pkg::OP_AS: begin
                mul_req.a    = 64'(r_arrive);
                mul_req.b    = {2'b00, r_span};
                mul_req.init = '0;
            end
            kfce_pkg::OP_H00: begin
                mul_req.a    = 64'(r_vl);
                mul_req.b    = kfce_pkg::hermite_basis(r_t, r_t2, r_t3, r_op);
                mul_req.init = '0;
            end
            kfce_pkg::OP_H01: begin
                mul_req.a = 64'(r_vr);
                mul_req.b = kfce_pkg::hermite_basis(r_t, r_t2, r_t3, r_op);
            end
            kfce_pkg::OP_H10: begin
                mul_req.a = 64'(r_ls);
                mul_req.b = kfce_pkg::hermite_basis(r_t, r_t2, r_t3, r_op);
            end
            kfce_pkg::OP_H11: begin
                mul_req.a = 64'(r_as);
                mul_req.b = kfce_pkg::hermite_basis(r_t, r_t2, r_t3, r_op);
            end
            default: begin
                mul_req.a = '0;
            end
        endcase
    end

    kfce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    kfce_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (cfg_wr) begin
            r_key_count <= pwdata[kfce_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfce_pkg::S_IDLE;
            r_ovld  <= 1'b0;
            r_first <= 1'b0;
            r_op    <= kfce_pkg::OP_LIN;
        end else begin
            r_ovld <= 1'b0;
            case (r_state)
                kfce_pkg::S_IDLE: begin
                    if (acc_eval) begin
                        if (n_keys == '0) begin
                            r_ovld <= 1'b1;
                            r_oval <= '0;
                        end else begin
                            r_state <= kfce_pkg::S_SCAN;
                            r_first <= 1'b1;
                            r_q     <= i_query_frame;
                            r_n     <= n_keys;
                            r_ridx  <= '0;
                            r_j     <= '0;
                        end
                    end
                end
                kfce_pkg::S_SCAN: begin
                    r_ridx <= r_ridx + 1'b1;
                    if (r_first) begin
                        // first read back is the last key, for the upper clamp
                        r_first      <= 1'b0;
                        r_last_frame <= r_rdata.frame;
                        r_last_level <= r_rdata.level;
                    end else if (r_j == '0) begin
                        if (r_q <= {r_rdata.frame, 8'd0}) begin
                            r_ovld  <= 1'b1;
                            r_oval  <= r_rdata.level;
                            r_state <= kfce_pkg::S_IDLE;
                        end else if (r_q >= {r_last_frame, 8'd0}) begin
                            r_ovld  <= 1'b1;
                            r_oval  <= r_last_level;
                            r_state <= kfce_pkg::S_IDLE;
                        end else begin
                            r_prev <= r_rdata;
                            r_j    <= r_j + 1'b1;
                        end
                    end else if (in_seg) begin
                        r_vl     <= r_prev.level;
                        r_vr     <= r_rdata.level;
                        r_leave  <= r_prev.leave;
                        r_arrive <= r_rdata.arrive;
                        r_span   <= span;
                        r_mode   <= r_prev.mode;
                        if (r_prev.mode == kfce_pkg::SEG_STEP) begin
                            r_ovld  <= 1'b1;
                            r_oval  <= r_prev.level;
                            r_state <= kfce_pkg::S_IDLE;
                        end else begin
                            r_state <= kfce_pkg::S_DIV;
                        end
                    end else if (r_j == r_n - CW'(1)) begin
                        // keys out of frame order or a skip segment: no segment holds the query
                        r_ovld  <= 1'b1;
                        r_oval  <= r_last_level;
                        r_state <= kfce_pkg::S_IDLE;
                    end else begin
                        r_prev <= r_rdata;
                        r_j    <= r_j + 1'b1;
                    end
                end
                kfce_pkg::S_DIV: begin
                    if (div_done) begin
                        r_t     <= div_quot;
                        r_op    <= (r_mode == kfce_pkg::SEG_LINEAR) ? kfce_pkg::OP_LIN
                                                                    : kfce_pkg::OP_T2;
                        r_state <= kfce_pkg::S_MLOAD;
                    end
                end
                kfce_pkg::S_MLOAD: begin
                    r_state <= kfce_pkg::S_MWAIT;
                end
                kfce_pkg::S_MWAIT: begin
                    if (mul_done) begin
                        r_state <= kfce_pkg::S_MLOAD;
                        case (r_op)
                            kfce_pkg::OP_LIN, kfce_pkg::OP_H11: begin
                                r_ovld  <= 1'b1;
                                r_oval  <= kfce_pkg::sat_q16(mul_acc);
                                r_state <= kfce_pkg::S_IDLE;
                            end
                            kfce_pkg::OP_T2: begin
                                r_t2 <= mul_acc[kfce_pkg::T2_W-1:0];
                                r_op <= kfce_pkg::OP_T3;
                            end
                            kfce_pkg::OP_T3: begin
                                r_t3 <= mul_acc[kfce_pkg::T3_W-1:0];
                                r_op <= kfce_pkg::OP_LS;
                            end
                            kfce_pkg::OP_LS: begin
                                r_ls <= mul_acc[kfce_pkg::SLP_W-1:0];
                                r_op <= kfce_pkg::OP_AS;
                            end
                            kfce_pkg::OP_AS: begin
                                r_as <= mul_acc[kfce_pkg::SLP_W-1:0];
                                r_op <= kfce_pkg::OP_H00;
                            end
                            kfce_pkg::OP_H00: r_op <= kfce_pkg::OP_H01;
                            kfce_pkg::OP_H01: r_op <= kfce_pkg::OP_H10;
                            kfce_pkg::OP_H10: r_op <= kfce_pkg::OP_H11;
                            default: r_state <= kfce_pkg::S_IDLE;
                        endcase
                    end
                end
                default: r_state <= kfce_pkg::S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_ovld;
    assign o_curve_value  = r_oval;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == kfce_pkg::S_DIV))
        else $error("divider finished outside the divide phase");

    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == kfce_pkg::S_MWAIT))
        else $error("multiplier finished outside the wait phase");

    a_empty_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_eval && (n_keys == '0)) |=> (o_result_valid && (o_curve_value == '0)))
        else $error("evaluate on an empty table did not return zero");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr |=> (!busy && !o_result_valid))
        else $error("write item made the block busy or gave a result");
`endif

endmodule
